// File: hdl/pps_pkg.sv
// ----------------------------------------------------------------------------
// Preemptive priority scheduler package
// Shared types and codes for the scheduler and its table cells.
// ----------------------------------------------------------------------------
`default_nettype none

package pps_pkg;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_t;

  // Best candidate found so far, handed from cell to cell during a scan.
  typedef struct packed {
    logic       found;
    logic [7:0] prio;
    logic [7:0] label;
    logic       work_one;
    logic [1:0] nwork;
  } carry_t;

endpackage

`default_nettype wire

// File: hdl/pps_cell.sv
// ----------------------------------------------------------------------------
// Scheduler table cell
// Holds one task entry and takes part in the selection wave along the chain.
// ----------------------------------------------------------------------------
`default_nettype none

module pps_cell #(
  parameter int NUM_ENTRIES = 16,
  parameter int CELL_INDEX  = 0
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic [$clog2(NUM_ENTRIES+1)-1:0]   count,
  input  wire logic [15:0]                        now,
  input  wire logic                               wr_en,
  input  wire logic [$clog2(NUM_ENTRIES)-1:0]     wr_idx,
  input  wire logic [7:0]                         wr_label,
  input  wire logic [15:0]                        wr_arrival,
  input  wire logic [15:0]                        wr_work,
  input  wire logic [7:0]                         wr_prio,
  input  wire logic                               dec_en,
  input  wire logic [$clog2(NUM_ENTRIES)-1:0]     dec_idx,
  input  wire logic                               wave_in,
  input  wire pps_pkg::carry_t                    carry_in,
  input  wire logic [$clog2(NUM_ENTRIES)-1:0]     pick_in,
  output logic                                    wave_out,
  output pps_pkg::carry_t                         carry_out,
  output logic [$clog2(NUM_ENTRIES)-1:0]          pick_out
);
  import pps_pkg::*;

  localparam int IW = $clog2(NUM_ENTRIES);
  localparam int CW = $clog2(NUM_ENTRIES + 1);

  logic [15:0] arrival;
  logic [15:0] work_left;
  logic [7:0]  prio;
  logic [7:0]  label;
  logic        loaded;
  logic        has_work;
  logic        eligible;
  logic        take;

  assign loaded   = CW'(CELL_INDEX) < count;
  assign has_work = loaded && (work_left != 16'd0);
  assign eligible = has_work && (arrival <= now);
  assign take     = eligible && (!carry_in.found || (prio > carry_in.prio));

  always_ff @(posedge clk) begin
    if (wr_en && (wr_idx == IW'(CELL_INDEX))) begin
      label     <= wr_label;
      arrival   <= wr_arrival;
      work_left <= wr_work;
      prio      <= wr_prio;
    end else if (dec_en && (dec_idx == IW'(CELL_INDEX))) begin
      work_left <= work_left - 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wave_out <= 1'b0;
    end else begin
      wave_out <= wave_in;
    end
  end

  always_ff @(posedge clk) begin
    if (wave_in) begin
      carry_out.found <= carry_in.found || eligible;
      if (take) begin
        carry_out.prio     <= prio;
        carry_out.label    <= label;
        carry_out.work_one <= (work_left == 16'd1);
        pick_out           <= IW'(CELL_INDEX);
      end else begin
        carry_out.prio     <= carry_in.prio;
        carry_out.label    <= carry_in.label;
        carry_out.work_one <= carry_in.work_one;
        pick_out           <= pick_in;
      end
      if (has_work) begin
        carry_out.nwork <= (carry_in.nwork == 2'd0) ? 2'd1 : 2'd2;
      end else begin
        carry_out.nwork <= carry_in.nwork;
      end
    end
  end

endmodule

`default_nettype wire

// File: hdl/preemptive_priority_scheduler.sv
// Timing: a load word is taken while idle; a tick word sends the selection wave
// through the row of table cells, then the update state registers the result word.
// A new tick word is taken only back in idle, after the wave has passed once
// through the row of table cells and the update state is done; a result word
// held by the receiver also holds the update.
// Reset clears the entry count, the time and the handshake state.
// ----------------------------------------------------------------------------
// Preemptive priority scheduler
// Loads tasks into a row of cells and, on each tick, runs the ready task of
// highest priority for one tick.
// ----------------------------------------------------------------------------
`default_nettype none

module preemptive_priority_scheduler #(
  parameter int MAX_ENTRIES = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        op,
  input  wire logic [7:0]  task_label,
  input  wire logic [15:0] arrival_tick,
  input  wire logic [15:0] work_ticks,
  input  wire logic [7:0]  priority_level,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [3:0]       slot,
  output logic [7:0]       run_label,
  output logic             idle,
  output logic [15:0]      tick_start,
  output logic             task_finished,
  output logic             all_done
);
  import pps_pkg::*;

  localparam int IW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  state_t         state;
  state_t         state_next;
  logic [CW-1:0]  entry_count;
  logic [15:0]    current_tick;

  logic           in_fire;
  logic           load_fire;
  logic           tick_fire;
  logic           update_fire;
  logic           out_free;

  logic           wave  [MAX_ENTRIES+1];
  carry_t         chain [MAX_ENTRIES+1];
  logic [IW-1:0]  pick  [MAX_ENTRIES+1];

  logic           done_tick;
  logic           run_tick;
  carry_t         result;

  assign in_fire   = in_valid && !in_stall;
  assign load_fire = in_fire && (op == OP_LOAD);
  assign tick_fire = in_fire && (op == OP_TICK);
  assign out_free  = !out_valid || !out_stall;
  assign result    = chain[MAX_ENTRIES];
  assign done_tick = (result.nwork == 2'd0);
  assign run_tick  = !done_tick && result.found;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_stall    = 1'b1;
    update_fire = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (tick_fire) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (wave[MAX_ENTRIES]) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (out_free) begin
          update_fire = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign wave[0]  = tick_fire;
  assign chain[0] = '0;
  assign pick[0]  = '0;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    pps_cell #(
      .NUM_ENTRIES (MAX_ENTRIES),
      .CELL_INDEX  (i)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .count      (entry_count),
      .now        (current_tick),
      .wr_en      (load_fire && (entry_count < CW'(MAX_ENTRIES))),
      .wr_idx     (entry_count[IW-1:0]),
      .wr_label   (task_label),
      .wr_arrival (arrival_tick),
      .wr_work    (work_ticks),
      .wr_prio    (priority_level),
      .dec_en     (update_fire && run_tick),
      .dec_idx    (pick[MAX_ENTRIES]),
      .wave_in    (wave[i]),
      .carry_in   (chain[i]),
      .pick_in    (pick[i]),
      .wave_out   (wave[i+1]),
      .carry_out  (chain[i+1]),
      .pick_out   (pick[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count  <= '0;
      current_tick <= 16'd0;
    end else begin
      if (load_fire && (entry_count < CW'(MAX_ENTRIES))) begin
        entry_count <= entry_count + CW'(1);
      end
      if (update_fire && !done_tick) begin
        current_tick <= current_tick + 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (update_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (update_fire) begin
      tick_start <= current_tick;
      if (run_tick) begin
        slot          <= 4'(pick[MAX_ENTRIES]);
        run_label     <= result.label;
        idle          <= 1'b0;
        task_finished <= result.work_one;
        all_done      <= result.work_one && (result.nwork == 2'd1);
      end else begin
        slot          <= 4'd0;
        run_label     <= 8'd0;
        idle          <= 1'b1;
        task_finished <= 1'b0;
        all_done      <= done_tick;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    wave[MAX_ENTRIES] |-> (state == ST_SCAN))
    else $error("Selection wave left the chain outside a scan.");

  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_UPDATE))
    else $error("Result word appeared without an update cycle.");

  assert property (@(posedge clk) disable iff (rst)
    entry_count <= CW'(MAX_ENTRIES))
    else $error("Entry count exceeds the table size.");

  assert property (@(posedge clk) disable iff (rst)
    (update_fire && done_tick) |=> $stable(current_tick))
    else $error("Time advanced on a done tick.");

  assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !load_fire)
    else $error("Load word taken during a tick.");

endmodule

`default_nettype wire
